// File: src/wsp_pkg.sv
// shared types and constants for the wheel speed period tachometer
// used by wsp_div and wheel_speed_period_tachometer; no dependencies
package wsp_pkg;

    localparam int WHEEL_COUNT_DEF = 4;
    localparam int CH_W            = 2;
    localparam int TS_W            = 16;
    localparam int NUM_W           = 32;
    localparam int RPM_W           = 16;

    localparam logic [NUM_W-1:0] RPM_NUM_RESET = 32'd60000;
    localparam logic [RPM_W-1:0] RPM_MAX       = 16'hffff;

    // divider result as seen by the sequencer
    typedef struct packed {
        logic             done;
        logic [RPM_W-1:0] quotient;
    } t_div_res;

endpackage

// File: src/wsp_div.sv
// restoring divider, one quotient bit per cycle, result saturated to 16 bits
// depends on wsp_pkg
module wsp_div import wsp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [TS_W-1:0]  i_divisor,
    output t_div_res         o_res
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_quo;
    logic [TS_W-1:0]  r_rem;
    logic [TS_W-1:0]  r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [TS_W:0]    trial;
    logic             ge;
    logic [TS_W:0]    diff;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    // any quotient bit above the low half means saturation
    assign o_res.done     = r_done;
    assign o_res.quotient = (|r_quo[NUM_W-1:RPM_W]) ? RPM_MAX : r_quo[RPM_W-1:0];

endmodule

// File: src/wheel_speed_period_tachometer.sv
// Wheel speed tachometer by period measurement. Each input item is one sensor
// edge: tuser carries the wheel channel, tdata the 16-bit timer count at the
// edge. The period is the difference to the channel's previous count modulo
// 2^16, and the output item gives rpm_numerator / period, zero for a zero
// period and saturated at 65535; the new count is stored either way. A channel
// at or beyond WHEEL_COUNT gives rpm 0 and leaves the stored counts alone. One
// item at a time: a nonzero period goes through the 32-step restoring divider,
// and the quotient is then registered; any other item goes straight to the
// output state. The output item can be taken in the same cycle it turns valid,
// and ready returns the cycle after that, so a new edge is accepted only after
// the previous output item has been taken.
// The numerator (reset 60000) is written through i_cfg_we / i_cfg_wdata and
// must only change while idle.
// depends on wsp_pkg and wsp_div
module wheel_speed_period_tachometer import wsp_pkg::*; #(
    parameter int WHEEL_COUNT = WHEEL_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [NUM_W-1:0] i_cfg_wdata,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [15:0]      i_s_axis_tdata,   // [15:0] timestamp
    input  logic [1:0]       i_s_axis_tuser,   // [1:0] channel
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [15:0] rpm
    output logic [1:0]       o_m_axis_tuser    // [1:0] wheel
);

    localparam int IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [NUM_W-1:0] r_num;
    logic [TS_W-1:0]  r_last [WHEEL_COUNT];
    logic [CH_W-1:0]  r_wheel;
    logic [RPM_W-1:0] r_rpm;

    logic             s_acc;
    logic             ch_ok;
    logic [IDX_W-1:0] idx;
    logic [TS_W-1:0]  period;
    logic             div_start;
    t_div_res         div_res;

    assign s_acc  = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign ch_ok  = (32'(i_s_axis_tuser) < WHEEL_COUNT);
    assign idx    = IDX_W'(i_s_axis_tuser);
    assign period = i_s_axis_tdata - (ch_ok ? r_last[idx] : '0);
    assign div_start = s_acc && ch_ok && (period != '0);

    wsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_num),
        .i_divisor  (period),
        .o_res      (div_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) n_state = div_start ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (div_res.done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_num   <= RPM_NUM_RESET;
            for (int i = 0; i < WHEEL_COUNT; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_num <= i_cfg_wdata;
            if (s_acc && ch_ok) r_last[idx] <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_wheel <= i_s_axis_tuser;
            r_rpm   <= '0;
        end else if ((r_state == ST_DIV) && div_res.done) begin
            r_rpm <= div_res.quotient;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tdata  = r_rpm;
    assign o_m_axis_tuser  = r_wheel;

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for wheel_speed_period_tachometer: sensor edge items in,
// speed items out, checked against a per-wheel period/divide predictor
// depends on wsp_pkg and the tachometer rtl
`timescale 1ns / 1ps

module tb;
    import wsp_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 200;
    localparam int RANDOM_PHASES = 8;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        logic [CH_W-1:0]  wheel;
        logic [RPM_W-1:0] rpm;
    } t_speed;

    // per-wheel edge timing and speed prediction, plus the queue of pending speeds
    class tach_scoreboard;
        logic [NUM_W-1:0] numerator;
        logic [TS_W-1:0]  last_edge[WHEEL_COUNT_DEF];
        t_speed           pending_speeds[$];
        int               errors;

        function new();
            numerator = RPM_NUM_RESET;
            foreach (last_edge[i]) last_edge[i] = '0;
            errors = 0;
        endfunction

        function logic [RPM_W-1:0] speed_for(logic [TS_W-1:0] period);
            logic [NUM_W-1:0] q;
            if (period == '0) return '0;
            q = numerator / period;
            if (q > RPM_MAX) return RPM_MAX;
            return q[RPM_W-1:0];
        endfunction

        function void note_edge(logic [CH_W-1:0] ch, logic [TS_W-1:0] stamp);
            t_speed           s;
            logic [TS_W-1:0]  period;
            s.wheel = ch;
            s.rpm   = '0;
            if (ch < WHEEL_COUNT_DEF) begin
                period         = stamp - last_edge[ch];
                s.rpm          = speed_for(period);
                last_edge[ch]  = stamp;
            end
            pending_speeds.push_back(s);
        endfunction

        function int pending();
            return pending_speeds.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            errors++;
        endtask

        task check_speed(logic [CH_W-1:0] wheel, logic [RPM_W-1:0] rpm);
            t_speed s;
            if (pending_speeds.size() == 0) begin
                report_mismatch($sformatf("unexpected item wheel=%0d rpm=%0d", wheel, rpm));
            end else begin
                s = pending_speeds.pop_front();
                if (wheel !== s.wheel)
                    report_mismatch($sformatf("wheel %0d, want %0d", wheel, s.wheel));
                if (rpm !== s.rpm)
                    report_mismatch($sformatf("rpm %0d, want %0d (wheel %0d)",
                                              rpm, s.rpm, s.wheel));
            end
        endtask

        task check_drained();
            if (pending_speeds.size() != 0)
                report_mismatch($sformatf("%0d speed items never arrived",
                                          pending_speeds.size()));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [NUM_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;   // [15:0] timestamp
    logic [1:0]       s_tuser;   // [1:0] channel
    logic             m_tvalid;
    logic             m_tready;
    logic [15:0]      m_tdata;   // [15:0] rpm
    logic [1:0]       m_tuser;   // [1:0] wheel

    tach_scoreboard sb;
    bit             calm;
    bit             long_hold_done;
    int             speeds_seen;
    int             cycles;

    wheel_speed_period_tachometer i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_speed(m_tuser, m_tdata);
            speeds_seen++;
        end
    end

    // receiver: random stall bursts, one long hold-off, steady ready at the end
    initial begin
        m_tready = 1'b0;
        wait (rst_n);
        forever begin
            if (!long_hold_done && speeds_seen >= 300) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_edge(input logic [CH_W-1:0] ch, input logic [TS_W-1:0] stamp);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= stamp;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_edge(ch, stamp);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_numerator(input logic [NUM_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        sb.numerator  = value;
    endtask

    // timestamps aimed at zero periods, wraps and the saturation boundary
    function automatic logic [TS_W-1:0] next_stamp(input logic [CH_W-1:0] ch);
        logic [TS_W-1:0] last;
        logic [TS_W-1:0] knee;
        last = sb.last_edge[ch];
        knee = sb.numerator[31:16];
        case ($urandom_range(0, 9))
            0, 1: return TS_W'($urandom);
            2:    return last;
            3:    return last + TS_W'($urandom_range(1, 16));
            4:    return last + knee + TS_W'($urandom_range(0, 2)) - 16'd1;
            5:    return last - TS_W'($urandom_range(1, 16));
            6:    return last + TS_W'($urandom_range(1, 255));
            default: return last + TS_W'($urandom_range(1, 4095));
        endcase
    endfunction

    initial begin
        logic [NUM_W-1:0] num;
        logic [CH_W-1:0]  ch;

        sb             = new();
        calm           = 1'b0;
        long_hold_done = 1'b0;
        speeds_seen    = 0;
        cycles         = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset numerator: first edges, zero period, wrap, longest period
        send_edge(2'd0, 16'h0000);
        send_edge(2'd1, 16'h0001);
        send_edge(2'd2, 16'hffff);
        send_edge(2'd3, 16'h8000);
        send_edge(2'd1, 16'h0001);
        send_edge(2'd1, 16'h0002);
        send_edge(2'd2, 16'h0000);
        send_edge(2'd3, 16'h7fff);
        send_edge(2'd0, 16'd60000);

        // largest numerator: saturation
        load_numerator(32'hffff_ffff);
        send_edge(2'd0, 16'hffff);
        send_edge(2'd0, 16'hffff);
        send_edge(2'd1, 16'h0001);
        send_edge(2'd2, 16'hffff);

        // quotient exactly at the top and one above
        load_numerator(32'hfffe_0001);
        send_edge(2'd3, 16'h7ffe);
        send_edge(2'd3, 16'h7ffc);

        load_numerator(32'd0);
        send_edge(2'd0, 16'h1234);
        send_edge(2'd1, 16'h0002);

        load_numerator(32'd1);
        send_edge(2'd2, 16'h0000);
        send_edge(2'd2, 16'h0001);
        send_edge(2'd3, 16'hfffb);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       num = RPM_NUM_RESET;
                1:       num = $urandom_range(0, 65535);
                2:       num = 32'hffff_ffff;
                3:       num = $urandom_range(65536, 32'h00ff_ffff);
                4:       num = 32'd0;
                5:       num = 32'hfffe_0001 + $urandom_range(0, 1000);
                default: num = $urandom;
            endcase
            load_numerator(num);
            if (phase == RANDOM_PHASES - 1) begin
                drain();
                calm = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                ch = CH_W'($urandom_range(0, WHEEL_COUNT_DEF - 1));
                send_edge(ch, next_stamp(ch));
            end
        end

        drain();
        repeat (40) @(negedge clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
